>>> hw/rtl/otb_pkg.sv
// shared constants and codes for the otsu threshold binarizer
`timescale 1ns / 1ps
`default_nettype none

package otb_pkg;

    localparam int unsigned MAX_PIXELS  = 4194304;
    localparam int unsigned GRAY_LEVELS = 256;

    localparam int unsigned GRAY_W = $clog2(GRAY_LEVELS);
    localparam int unsigned BIN_W  = $clog2(MAX_PIXELS + 1);
    localparam int unsigned SUM_W  = BIN_W + GRAY_W;

    // search datapath widths
    localparam int unsigned P_W   = BIN_W + SUM_W;
    localparam int unsigned NUM_W = 2 * P_W;
    localparam int unsigned DEN_W = 2 * BIN_W;
    localparam int unsigned CMP_W = NUM_W + DEN_W;

    // shift-add multiplier
    localparam int unsigned MCAND_W   = NUM_W;
    localparam int unsigned MPLR_W    = P_W;
    localparam int unsigned PROD_W    = MCAND_W + MPLR_W;
    localparam int unsigned MUL_CNT_W = $clog2(MPLR_W + 1);

    localparam logic FUNC_ACCUM    = 1'b0;
    localparam logic FUNC_BINARIZE = 1'b1;

    localparam logic KIND_PIXEL     = 1'b0;
    localparam logic KIND_THRESHOLD = 1'b1;

    localparam logic [GRAY_W-1:0] PIXEL_ON  = '1;
    localparam logic [GRAY_W-1:0] PIXEL_OFF = '0;

endpackage

`default_nettype wire

>>> hw/rtl/otb_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module otb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/otsu_threshold_binarizer_core.sv
// top level of the otsu threshold binarizer
`timescale 1ns / 1ps
`default_nettype none

// usage
//   input words: func, gray_value, frame_end, taken at a rising edge with start high and
//   busy low. func accumulate counts the pixel into a 256-bin histogram held in one ram;
//   frame_end on an accumulate word closes the frame and starts the threshold search.
//   func binarize compares the pixel with the held threshold.
//   result words: done is high for one cycle with result_kind and value; the receiver
//   cannot stall, so each result is taken in that cycle.
// timing
//   accumulate words are taken one per cycle; the histogram update is a read-modify-write
//   with a registered ram read and forwarding from the previous write, so equal bins
//   back to back are fine. binarize words are taken one per cycle and give their result
//   in the next cycle. a frame_end word sets busy for the search: a drain state, then the
//   read, eval and acc states per bin, with six shift-add multiplier passes before acc when
//   both classes are non-empty. the threshold word comes out in the cycle after the last acc.
// reset
//   a clearing pass writes zero to all 256 histogram bins with busy high;
//   totals and the held threshold reset to zero.

module otsu_threshold_binarizer_core
    import otb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              func,
    input  wire logic [GRAY_W-1:0] gray_value,
    input  wire logic              frame_end,
    output logic                   done,
    output logic                   result_kind,
    output logic      [GRAY_W-1:0] value
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DRAIN = 4'd2;
    localparam logic [3:0] S_READ  = 4'd3;
    localparam logic [3:0] S_EVAL  = 4'd4;
    localparam logic [3:0] S_MP    = 4'd5;
    localparam logic [3:0] S_MQ    = 4'd6;
    localparam logic [3:0] S_MD    = 4'd7;
    localparam logic [3:0] S_MN    = 4'd8;
    localparam logic [3:0] S_ML    = 4'd9;
    localparam logic [3:0] S_MR    = 4'd10;
    localparam logic [3:0] S_ACC   = 4'd11;

    localparam logic [GRAY_W-1:0]    LAST_BIN  = GRAY_W'(GRAY_LEVELS - 1);
    localparam logic [MUL_CNT_W-1:0] MUL_STEPS = MUL_CNT_W'(MPLR_W);
    localparam logic [BIN_W-1:0]     PIX_LIMIT = BIN_W'(MAX_PIXELS);

    // control state
    logic [3:0]           state_reg, state_next;
    logic [GRAY_W-1:0]    t_reg, t_next;
    logic                 done_reg, done_next;
    logic                 pix_valid_reg, pix_valid_next;
    logic                 wb_valid_reg, wb_valid_next;
    logic [MUL_CNT_W-1:0] mul_cnt_reg, mul_cnt_next;
    logic [BIN_W-1:0]     pixel_total_reg, pixel_total_next;
    logic [SUM_W-1:0]     weighted_total_reg, weighted_total_next;
    logic [GRAY_W-1:0]    threshold_reg, threshold_next;

    // datapath
    logic                 kind_reg, kind_next;
    logic [GRAY_W-1:0]    value_reg, value_next;
    logic [GRAY_W-1:0]    pix_addr_reg, pix_addr_next;
    logic [GRAY_W-1:0]    wb_addr_reg, wb_addr_next;
    logic [BIN_W-1:0]     wb_data_reg, wb_data_next;
    logic [BIN_W-1:0]     bin_reg, bin_next;
    logic [BIN_W-1:0]     n0_reg, n0_next;
    logic [SUM_W-1:0]     s0_reg, s0_next;
    logic [P_W-1:0]       p_reg, p_next;
    logic [NUM_W-1:0]     num_reg, num_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic [CMP_W-1:0]     lhs_reg, lhs_next;
    logic [NUM_W-1:0]     best_num_reg, best_num_next;
    logic [DEN_W-1:0]     best_den_reg, best_den_next;
    logic [GRAY_W-1:0]    best_t_reg, best_t_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [MCAND_W-1:0]   mcand_reg, mcand_next;

    // ram port
    logic                 ram_we;
    logic [GRAY_W-1:0]    ram_waddr;
    logic [BIN_W-1:0]     ram_wdata;
    logic [GRAY_W-1:0]    ram_raddr;
    logic [BIN_W-1:0]     ram_rdata;

    logic                 accept;
    logic                 count_ok;
    logic [BIN_W-1:0]     bin_cur;
    logic [BIN_W-1:0]     bin_inc;
    logic [BIN_W-1:0]     n1;
    logic [SUM_W-1:0]     s1;
    logic [SUM_W-1:0]     bin_weight;
    logic [P_W-1:0]       q_val;
    logic [P_W-1:0]       d_val;
    logic                 mul_done;
    logic                 mul_load;
    logic [MCAND_W-1:0]   mul_a;
    logic [MPLR_W-1:0]    mul_b;
    logic [MCAND_W:0]     mul_sum;

    otb_ram #(
        .WIDTH (BIN_W),
        .DEPTH (GRAY_LEVELS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy        = (state_reg != S_IDLE);
    assign accept      = start && !busy;
    assign done        = done_reg;
    assign result_kind = kind_reg;
    assign value       = value_reg;

    assign count_ok = (pixel_total_reg < PIX_LIMIT);

    // forward the bin written last cycle, the ram read saw the old count
    assign bin_cur = (wb_valid_reg && (wb_addr_reg == pix_addr_reg)) ? wb_data_reg : ram_rdata;
    assign bin_inc = bin_cur + BIN_W'(1);

    // class 1 is everything not yet swept into class 0
    assign n1         = pixel_total_reg - n0_reg;
    assign s1         = weighted_total_reg - s0_reg;
    assign bin_weight = SUM_W'(bin_reg) * SUM_W'(t_reg);

    assign q_val = prod_reg[P_W-1:0];
    assign d_val = (p_reg >= q_val) ? (p_reg - q_val) : (q_val - p_reg);

    assign mul_done = (mul_cnt_reg == MUL_STEPS);
    assign mul_sum  = {1'b0, prod_reg[PROD_W-1:MPLR_W]} + {1'b0, mcand_reg};

    always_comb
    begin
        state_next          = state_reg;
        t_next              = t_reg;
        done_next           = 1'b0;
        pix_valid_next      = 1'b0;
        wb_valid_next       = pix_valid_reg;
        pixel_total_next    = pixel_total_reg;
        weighted_total_next = weighted_total_reg;
        threshold_next      = threshold_reg;
        kind_next           = kind_reg;
        value_next          = value_reg;
        pix_addr_next       = pix_addr_reg;
        wb_addr_next        = pix_addr_reg;
        wb_data_next        = bin_inc;
        bin_next            = bin_reg;
        n0_next             = n0_reg;
        s0_next             = s0_reg;
        p_next              = p_reg;
        num_next            = num_reg;
        den_next            = den_reg;
        lhs_next            = lhs_reg;
        best_num_next       = best_num_reg;
        best_den_next       = best_den_reg;
        best_t_next         = best_t_reg;
        mul_load            = 1'b0;
        mul_a               = '0;
        mul_b               = '0;

        ram_raddr = t_reg;
        ram_we    = 1'b0;
        ram_waddr = t_reg;
        ram_wdata = '0;

        // write back of the pixel accepted last cycle
        if (pix_valid_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = pix_addr_reg;
            ram_wdata = bin_inc;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
                t_next = t_reg + GRAY_W'(1);
                if (t_reg == LAST_BIN)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                ram_raddr = gray_value;
                if (accept)
                begin
                    if (func == FUNC_BINARIZE)
                    begin
                        done_next  = 1'b1;
                        kind_next  = KIND_PIXEL;
                        value_next = (gray_value >= threshold_reg) ? PIXEL_ON : PIXEL_OFF;
                    end
                    else
                    begin
                        if (count_ok)
                        begin
                            pix_valid_next      = 1'b1;
                            pix_addr_next       = gray_value;
                            pixel_total_next    = pixel_total_reg + BIN_W'(1);
                            weighted_total_next = weighted_total_reg + SUM_W'(gray_value);
                        end
                        if (frame_end)
                        begin
                            state_next = S_DRAIN;
                        end
                    end
                end
            end
            S_DRAIN:
            begin
                // last pixel lands in the ram this cycle
                t_next        = '0;
                n0_next       = '0;
                s0_next       = '0;
                best_num_next = '0;
                best_den_next = DEN_W'(1);
                best_t_next   = '0;
                state_next    = S_READ;
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                bin_next = ram_rdata;
                ram_we   = 1'b1;
                if ((n0_reg != '0) && (n1 != '0))
                begin
                    mul_load   = 1'b1;
                    mul_a      = MCAND_W'(s0_reg);
                    mul_b      = MPLR_W'(n1);
                    state_next = S_MP;
                end
                else
                begin
                    state_next = S_ACC;
                end
            end
            S_MP:
            begin
                if (mul_done)
                begin
                    p_next     = prod_reg[P_W-1:0];
                    mul_load   = 1'b1;
                    mul_a      = MCAND_W'(s1);
                    mul_b      = MPLR_W'(n0_reg);
                    state_next = S_MQ;
                end
            end
            S_MQ:
            begin
                if (mul_done)
                begin
                    mul_load   = 1'b1;
                    mul_a      = MCAND_W'(d_val);
                    mul_b      = MPLR_W'(d_val);
                    state_next = S_MD;
                end
            end
            S_MD:
            begin
                if (mul_done)
                begin
                    num_next   = prod_reg[NUM_W-1:0];
                    mul_load   = 1'b1;
                    mul_a      = MCAND_W'(n0_reg);
                    mul_b      = MPLR_W'(n1);
                    state_next = S_MN;
                end
            end
            S_MN:
            begin
                if (mul_done)
                begin
                    den_next   = prod_reg[DEN_W-1:0];
                    mul_load   = 1'b1;
                    mul_a      = num_reg;
                    mul_b      = MPLR_W'(best_den_reg);
                    state_next = S_ML;
                end
            end
            S_ML:
            begin
                if (mul_done)
                begin
                    lhs_next   = prod_reg[CMP_W-1:0];
                    mul_load   = 1'b1;
                    mul_a      = best_num_reg;
                    mul_b      = MPLR_W'(den_reg);
                    state_next = S_MR;
                end
            end
            S_MR:
            begin
                if (mul_done)
                begin
                    // strict compare keeps the first maximum
                    if (lhs_reg > prod_reg[CMP_W-1:0])
                    begin
                        best_num_next = num_reg;
                        best_den_next = den_reg;
                        best_t_next   = t_reg;
                    end
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                n0_next = n0_reg + bin_reg;
                s0_next = s0_reg + bin_weight;
                t_next  = t_reg + GRAY_W'(1);
                if (t_reg == LAST_BIN)
                begin
                    threshold_next      = best_t_reg;
                    done_next           = 1'b1;
                    kind_next           = KIND_THRESHOLD;
                    value_next          = best_t_reg;
                    pixel_total_next    = '0;
                    weighted_total_next = '0;
                    state_next          = S_IDLE;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // shift-add multiplier, one multiplier bit per cycle
        mul_cnt_next = mul_cnt_reg;
        prod_next    = prod_reg;
        mcand_next   = mcand_reg;
        if (mul_load)
        begin
            mul_cnt_next = '0;
            prod_next    = {{MCAND_W{1'b0}}, mul_b};
            mcand_next   = mul_a;
        end
        else if (!mul_done)
        begin
            mul_cnt_next = mul_cnt_reg + MUL_CNT_W'(1);
            if (prod_reg[0])
            begin
                prod_next = {mul_sum, prod_reg[MPLR_W-1:1]};
            end
            else
            begin
                prod_next = {1'b0, prod_reg[PROD_W-1:1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_CLEAR;
            t_reg              <= '0;
            done_reg           <= 1'b0;
            pix_valid_reg      <= 1'b0;
            wb_valid_reg       <= 1'b0;
            mul_cnt_reg        <= MUL_STEPS;
            pixel_total_reg    <= '0;
            weighted_total_reg <= '0;
            threshold_reg      <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            t_reg              <= t_next;
            done_reg           <= done_next;
            pix_valid_reg      <= pix_valid_next;
            wb_valid_reg       <= wb_valid_next;
            mul_cnt_reg        <= mul_cnt_next;
            pixel_total_reg    <= pixel_total_next;
            weighted_total_reg <= weighted_total_next;
            threshold_reg      <= threshold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        value_reg    <= value_next;
        pix_addr_reg <= pix_addr_next;
        wb_addr_reg  <= wb_addr_next;
        wb_data_reg  <= wb_data_next;
        bin_reg      <= bin_next;
        n0_reg       <= n0_next;
        s0_reg       <= s0_next;
        p_reg        <= p_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        lhs_reg      <= lhs_next;
        best_num_reg <= best_num_next;
        best_den_reg <= best_den_next;
        best_t_reg   <= best_t_next;
        prod_reg     <= prod_next;
        mcand_reg    <= mcand_next;
    end

`ifndef SYNTHESIS
    // a threshold word only follows the last bin step
    a_thresh_after_search: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result_kind == KIND_THRESHOLD)) |-> ($past(state_reg) == S_ACC))
        else $error("threshold word without a finished search");

    // pixel write back never overlaps the search or the clearing pass
    a_pix_wb_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid_reg |-> ((state_reg == S_IDLE) || (state_reg == S_DRAIN)))
        else $error("histogram update during search");

    a_mul_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        mul_cnt_reg <= MUL_STEPS)
        else $error("multiplier step count out of range");

    a_total_limit: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_total_reg <= PIX_LIMIT)
        else $error("pixel count above frame limit");

    // closing a frame must start the search
    a_frame_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (func == FUNC_ACCUM) && frame_end) |=> busy)
        else $error("frame end did not start the search");
`endif

endmodule

`default_nettype wire

>>> bench/otsu_threshold_binarizer_core_tb.sv
// self-checking testbench for the otsu threshold binarizer core
`timescale 1ns / 1ps

module otsu_threshold_binarizer_core_tb;
    import otb_pkg::*;

    // run limit: two full-range searches, plus up to about two hundred random
    // frames, plus idle gaps, with ample room on top
    localparam int unsigned RUN_LIMIT    = 10000000;
    localparam int unsigned RANDOM_WORDS = 1150;
    localparam int unsigned IDLE_PCT     = 27;

    typedef logic [191:0] wide_t;

    // one expected result word
    typedef struct {
        logic              kind;
        logic [GRAY_W-1:0] value;
    } result_word_t;

    // one row of the directed table; fixed rows carry a hand-written result
    typedef struct {
        logic              func_b;
        logic [GRAY_W-1:0] gray;
        logic              fend;
        bit                fixed;
        logic              kind;
        logic [GRAY_W-1:0] value;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              func;
    logic [GRAY_W-1:0] gray_value;
    logic              frame_end;
    logic              done;
    logic              result_kind;
    logic [GRAY_W-1:0] value;

    // hand-written expectation that travels with the driven word
    bit                fixed_valid;
    logic              fixed_kind;
    logic [GRAY_W-1:0] fixed_value;

    // mirror of the block state
    logic [BIN_W-1:0]  hist_mirror [GRAY_LEVELS];
    logic [BIN_W-1:0]  pixel_total;
    logic [SUM_W-1:0]  weighted_total;
    logic [GRAY_W-1:0] thr_held;

    result_word_t      expected_words [$];
    stim_row_t         directed_rows [$];

    int unsigned       cycle_count = 0;
    int unsigned       mismatch_count = 0;
    int unsigned       words_in = 0;
    int unsigned       pixels_checked = 0;
    int unsigned       thresholds_checked = 0;
    int unsigned       words_sent = 0;
    int unsigned       frame_no = 0;
    bit                idle_on = 1'b1;

    otsu_threshold_binarizer_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .gray_value  (gray_value),
        .frame_end   (frame_end),
        .done        (done),
        .result_kind (result_kind),
        .value       (value)
    );

    always #4 clk = ~clk;

    always @(posedge clk) cycle_count++;

    // exhaustive search over all split points, exact cross-multiplied compare;
    // empty classes are skipped and the first strict maximum wins
    function automatic logic [GRAY_W-1:0] otsu_search();
        logic [63:0]       n0;
        logic [63:0]       s0;
        logic [63:0]       n1;
        logic [63:0]       s1;
        wide_t             p;
        wide_t             q;
        wide_t             d;
        wide_t             num;
        wide_t             den;
        wide_t             best_num;
        wide_t             best_den;
        logic [GRAY_W-1:0] best_t;
        n0       = '0;
        s0       = '0;
        best_num = '0;
        best_den = wide_t'(1);
        best_t   = '0;
        for (int t = 0; t < GRAY_LEVELS; t++)
        begin
            n1 = 64'(pixel_total) - n0;
            s1 = 64'(weighted_total) - s0;
            if (n0 != '0 && n1 != '0)
            begin
                p   = wide_t'(n1) * wide_t'(s0);
                q   = wide_t'(n0) * wide_t'(s1);
                d   = (p >= q) ? p - q : q - p;
                num = d * d;
                den = wide_t'(n0 * n1);
                if (num * best_den > best_num * den)
                begin
                    best_num = num;
                    best_den = den;
                    best_t   = GRAY_W'(t);
                end
            end
            n0 = n0 + 64'(hist_mirror[t]);
            s0 = s0 + 64'(hist_mirror[t]) * 64'(t);
        end
        return best_t;
    endfunction

    // next state and result of one accepted word; returns 1 when a result is due
    function automatic bit otsu_predict_word(input logic f, input logic [GRAY_W-1:0] g,
                                             input logic fe, output logic k,
                                             output logic [GRAY_W-1:0] v);
        int bin;
        k   = KIND_PIXEL;
        v   = PIXEL_OFF;
        bin = int'(g);
        if (f == FUNC_BINARIZE)
        begin
            // frame_end is ignored in the binarize pass
            v = (g >= thr_held) ? PIXEL_ON : PIXEL_OFF;
            return 1'b1;
        end
        // gray above range lands in the top bin
        if (bin >= GRAY_LEVELS)
            bin = GRAY_LEVELS - 1;
        // an overlong frame stops counting but still closes on frame_end
        if (pixel_total < MAX_PIXELS)
        begin
            hist_mirror[bin] = hist_mirror[bin] + BIN_W'(1);
            pixel_total      = pixel_total + BIN_W'(1);
            weighted_total   = weighted_total + SUM_W'(bin);
        end
        if (!fe)
            return 1'b0;
        thr_held = otsu_search();
        for (int i = 0; i < GRAY_LEVELS; i++)
            hist_mirror[i] = '0;
        pixel_total    = '0;
        weighted_total = '0;
        k = KIND_THRESHOLD;
        v = thr_held;
        return 1'b1;
    endfunction

    // result check first (it belongs to an older word), then prediction of
    // the word taken at this edge
    always @(posedge clk)
    begin
        result_word_t      exp_word;
        result_word_t      due_word;
        logic              pk;
        logic [GRAY_W-1:0] pv;
        bit                due;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result word with none pending: result_kind %0d value %0d",
                           result_kind, value);
                    mismatch_count++;
                end
                else
                begin
                    exp_word = expected_words.pop_front();
                    if (result_kind !== exp_word.kind)
                    begin
                        $error("result_kind mismatch: expected %0d, actual %0d",
                               exp_word.kind, result_kind);
                        mismatch_count++;
                    end
                    if (value !== exp_word.value)
                    begin
                        $error("value mismatch: expected %0d, actual %0d",
                               exp_word.value, value);
                        mismatch_count++;
                    end
                    if (exp_word.kind == KIND_THRESHOLD)
                        thresholds_checked++;
                    else
                        pixels_checked++;
                end
            end
            if (start && !busy)
            begin
                words_in++;
                due = otsu_predict_word(func, gray_value, frame_end, pk, pv);
                if (due)
                begin
                    // a hand-written row overrides the mirror's answer
                    if (fixed_valid)
                    begin
                        due_word.kind  = fixed_kind;
                        due_word.value = fixed_value;
                    end
                    else
                    begin
                        due_word.kind  = pk;
                        due_word.value = pv;
                    end
                    expected_words.insert(expected_words.size(), due_word);
                end
            end
        end
    end

    // drive one word from a falling edge, hold it until taken, return on the
    // falling edge after the taking edge
    task automatic send_word(input logic f, input logic [GRAY_W-1:0] g, input logic fe,
                             input bit fx, input logic fk, input logic [GRAY_W-1:0] fv);
        bit taken;
        taken = 1'b0;
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start       <= 1'b1;
        func        <= f;
        gray_value  <= g;
        frame_end   <= fe;
        fixed_valid <= fx;
        fixed_kind  <= fk;
        fixed_value <= fv;
        while (!taken)
        begin
            @(posedge clk);
            taken = !busy;
        end
        words_sent++;
        @(negedge clk);
    endtask

    task automatic add_row(input logic f, input int g, input logic fe,
                           input int fx, input logic fk, input int fv);
        stim_row_t row;
        row.func_b = f;
        row.gray   = GRAY_W'(g);
        row.fend   = fe;
        row.fixed  = (fx != 0);
        row.kind   = fk;
        row.value  = GRAY_W'(fv);
        directed_rows.insert(directed_rows.size(), row);
    endtask

    function automatic logic [GRAY_W-1:0] clamp_gray(input int g);
        if (g < 0)
            return '0;
        if (g > 255)
            return 8'd255;
        return GRAY_W'(g);
    endfunction

    // timeout watchdog
    initial
    begin
        wait (cycle_count >= RUN_LIMIT);
        $display("timeout after %0d cycles, %0d words still pending",
                 cycle_count, expected_words.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int               base;
        int               span;
        int               len;
        int               burst;
        int               g;
        bit               wide_frame;
        logic [GRAY_W-1:0] pix;

        for (int i = 0; i < GRAY_LEVELS; i++)
            hist_mirror[i] = '0;
        pixel_total    = '0;
        weighted_total = '0;
        thr_held       = '0;

        rst_n       = 1'b0;
        start       = 1'b0;
        func        = FUNC_ACCUM;
        gray_value  = '0;
        frame_end   = 1'b0;
        fixed_valid = 1'b0;
        fixed_kind  = KIND_PIXEL;
        fixed_value = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        // held threshold is zero after reset, so every pixel is on
        add_row(FUNC_BINARIZE, 0,   1'b0, 1, KIND_PIXEL, 255);
        add_row(FUNC_BINARIZE, 255, 1'b0, 1, KIND_PIXEL, 255);
        // frame_end on a binarize word does nothing extra
        add_row(FUNC_BINARIZE, 128, 1'b1, 1, KIND_PIXEL, 255);
        // single-pixel frame: no split has both classes, threshold 0
        add_row(FUNC_ACCUM,    77,  1'b1, 1, KIND_THRESHOLD, 0);
        // frame of one gray level: zero variance everywhere, threshold 0
        add_row(FUNC_ACCUM,    100, 1'b0, 0, KIND_PIXEL, 0);
        add_row(FUNC_ACCUM,    100, 1'b0, 0, KIND_PIXEL, 0);
        add_row(FUNC_ACCUM,    100, 1'b0, 0, KIND_PIXEL, 0);
        add_row(FUNC_ACCUM,    100, 1'b1, 1, KIND_THRESHOLD, 0);
        // extremes only: every split 1..255 ties, first one wins
        add_row(FUNC_ACCUM,    0,   1'b0, 0, KIND_PIXEL, 0);
        add_row(FUNC_ACCUM,    255, 1'b0, 0, KIND_PIXEL, 0);
        add_row(FUNC_ACCUM,    0,   1'b0, 0, KIND_PIXEL, 0);
        add_row(FUNC_ACCUM,    255, 1'b1, 1, KIND_THRESHOLD, 1);
        add_row(FUNC_BINARIZE, 0,   1'b0, 1, KIND_PIXEL, 0);
        add_row(FUNC_BINARIZE, 1,   1'b1, 1, KIND_PIXEL, 255);
        add_row(FUNC_BINARIZE, 255, 1'b0, 1, KIND_PIXEL, 255);
        // two levels: first tie at one above the lower level
        add_row(FUNC_ACCUM,    10,  1'b0, 0, KIND_PIXEL, 0);
        add_row(FUNC_ACCUM,    20,  1'b1, 1, KIND_THRESHOLD, 11);
        add_row(FUNC_BINARIZE, 10,  1'b0, 1, KIND_PIXEL, 0);
        add_row(FUNC_BINARIZE, 11,  1'b0, 1, KIND_PIXEL, 255);
        // uneven frame, checked by the mirror
        add_row(FUNC_ACCUM,    30,  1'b0, 0, KIND_PIXEL, 0);
        add_row(FUNC_ACCUM,    31,  1'b0, 0, KIND_PIXEL, 0);
        add_row(FUNC_ACCUM,    31,  1'b0, 0, KIND_PIXEL, 0);
        add_row(FUNC_ACCUM,    40,  1'b0, 0, KIND_PIXEL, 0);
        add_row(FUNC_ACCUM,    45,  1'b1, 0, KIND_PIXEL, 0);
        add_row(FUNC_BINARIZE, 170, 1'b0, 0, KIND_PIXEL, 0);
        add_row(FUNC_BINARIZE, 35,  1'b1, 0, KIND_PIXEL, 0);

        foreach (directed_rows[i])
            send_word(directed_rows[i].func_b, directed_rows[i].gray, directed_rows[i].fend,
                      directed_rows[i].fixed, directed_rows[i].kind, directed_rows[i].value);

        // random frames: mostly well-formed accumulate frames of narrow gray span
        // (cheap search), each followed by a burst of binarize words
        while (words_sent < RANDOM_WORDS + directed_rows.size())
        begin
            frame_no++;
            // stretch with no idle cycles at all
            idle_on    = !(frame_no >= 6 && frame_no <= 10);
            wide_frame = (frame_no == 14);
            base = $urandom_range(0, 255);
            if (wide_frame)
            begin
                base = 0;
                span = 255;
            end
            else if ($urandom_range(0, 9) == 0)
                span = $urandom_range(10, 30);
            else
                span = $urandom_range(0, 9);
            len = wide_frame ? 64 : $urandom_range(2, 40);
            for (int i = 0; i < len; i++)
            begin
                // noise: a stray binarize word inside the frame
                if ($urandom_range(0, 99) < 5)
                    send_word(FUNC_BINARIZE, GRAY_W'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 1'b0, KIND_PIXEL, '0);
                g = base + $urandom_range(0, span);
                if (wide_frame && i == 0)
                    g = 0;
                if (wide_frame && i == len - 1)
                    g = 255;
                send_word(FUNC_ACCUM, clamp_gray(g), (i == len - 1), 1'b0, KIND_PIXEL, '0);
            end
            burst = $urandom_range(4, 30);
            for (int i = 0; i < burst; i++)
            begin
                // half the pixels sit right around the held threshold
                if ($urandom_range(0, 1) == 0)
                    pix = clamp_gray(int'(thr_held) + $urandom_range(0, 4) - 2);
                else
                    pix = GRAY_W'($urandom_range(0, 255));
                send_word(FUNC_BINARIZE, pix, 1'($urandom_range(0, 1)), 1'b0, KIND_PIXEL, '0);
            end
        end
        start <= 1'b0;
        idle_on = 1'b1;

        // drain, then a short settle for any stray result
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("covered %0d words over %0d random frames plus the directed table",
                 words_in, frame_no);
        $display("checked %0d binarized pixels and %0d thresholds in %0d cycles",
                 pixels_checked, thresholds_checked, cycle_count);
        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
